// ----- rtl/pva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and codes for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int KEY_W    = 7;
    localparam int VEL_W    = 7;
    localparam int VOICE_W  = 2;
    localparam int ACTION_W = 2;

    typedef enum logic {
        OP_NOTE_ON  = 1'b0,
        OP_NOTE_OFF = 1'b1
    } t_op;

    typedef enum logic [ACTION_W-1:0] {
        ACT_VEL_CHANGE = 2'd0,
        ACT_START      = 2'd1,
        ACT_SILENCE    = 2'd2
    } t_action;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [VEL_W-1:0] velocity;
    } t_in_req;

    typedef struct packed {
        logic [VOICE_W-1:0]  voice;
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    note_key;
        logic [VEL_W-1:0]    level;
        logic                stolen;
    } t_out_rsp;

endpackage

// ----- rtl/pva_voice_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_voice_cell
// One voice slot: holds its key and busy flag, compares against the request
// key and passes the key-hit and free-voice search on to the next cell.
// ----------------------------------------------------------------------------
module pva_voice_cell #(
    parameter int IDX_W = 2,
    parameter int INDEX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pva_pkg::KEY_W-1:0] i_key,
    input  logic                      i_load,
    input  logic                      i_clear,
    input  logic                      i_hit,
    input  logic [IDX_W-1:0]          i_hit_idx,
    input  logic                      i_free,
    input  logic [IDX_W-1:0]          i_free_idx,
    output logic                      o_hit,
    output logic [IDX_W-1:0]          o_hit_idx,
    output logic                      o_free,
    output logic [IDX_W-1:0]          o_free_idx
);
    import pva_pkg::*;

    logic             r_busy;
    logic             n_busy;
    logic [KEY_W-1:0] r_key;
    logic             match;

    assign match = r_busy && (r_key == i_key);

    always_comb begin
        n_busy = r_busy;
        if (i_load) begin
            n_busy = 1'b1;
        end else if (i_clear) begin
            n_busy = 1'b0;
        end
    end

    // lowest matching voice wins, highest free voice wins
    always_comb begin
        o_hit      = i_hit;
        o_hit_idx  = i_hit_idx;
        o_free     = i_free;
        o_free_idx = i_free_idx;
        if (!i_hit && match) begin
            o_hit     = 1'b1;
            o_hit_idx = IDX_W'(INDEX);
        end
        if (!r_busy) begin
            o_free     = 1'b1;
            o_free_idx = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_key;
        end
    end

endmodule

// ----- rtl/pva_hist_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_hist_cell
// One slot of the allocation history; shifts its neighbor's voice index in
// on every new allocation.
// ----------------------------------------------------------------------------
module pva_hist_cell #(
    parameter int IDX_W = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [IDX_W-1:0] i_din,
    output logic [IDX_W-1:0] o_slot
);
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] n_slot;

    assign n_slot = i_shift ? i_din : r_slot;
    assign o_slot = r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

// ----- rtl/polyphonic_voice_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// Assigns note-on and note-off requests to voices with oldest-note stealing.
// ----------------------------------------------------------------------------
// One request is taken per clock unless stalled; its result, if any, appears
// in the output register on the next cycle. The input stalls only while that
// register is full and the output stalls. The cycle time is set by the key
// and free-voice search rippling through the chain of VOICE_COUNT voice cells.
// Reset leaves all voices free and the history all zero; no clearing pass.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator #(
    parameter int VOICE_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pva_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pva_pkg::t_out_rsp o_out_rsp
);
    import pva_pkg::*;

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int EXT_W = (IDX_W > VOICE_W) ? IDX_W : VOICE_W;

    logic                              accept;
    logic                              is_on;
    logic [VOICE_COUNT:0]              hit_c;
    logic [VOICE_COUNT:0]              free_c;
    logic [VOICE_COUNT:0][IDX_W-1:0]   hit_idx_c;
    logic [VOICE_COUNT:0][IDX_W-1:0]   free_idx_c;
    logic [VOICE_COUNT-1:0][IDX_W-1:0] hist;
    logic                              hit;
    logic                              any_free;
    logic [IDX_W-1:0]                  hit_idx;
    logic [IDX_W-1:0]                  pick;
    logic                              alloc;
    logic [EXT_W-1:0]                  voice_ext;
    logic                              r_out_valid;
    logic                              n_out_valid;
    t_out_rsp                          r_out_rsp;
    t_out_rsp                          n_out_rsp;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_on      = (i_in_req.op == OP_NOTE_ON);

    assign hit_c[0]      = 1'b0;
    assign free_c[0]     = 1'b0;
    assign hit_idx_c[0]  = '0;
    assign free_idx_c[0] = '0;

    assign hit      = hit_c[VOICE_COUNT];
    assign hit_idx  = hit_idx_c[VOICE_COUNT];
    assign any_free = free_c[VOICE_COUNT];
    assign pick     = any_free ? free_idx_c[VOICE_COUNT] : hist[VOICE_COUNT-1];
    assign alloc    = accept && is_on && !hit;

    genvar g;
    generate
        for (g = 0; g < VOICE_COUNT; g++) begin : g_voice
            pva_voice_cell #(
                .IDX_W (IDX_W),
                .INDEX (g)
            ) u_voice (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_key      (i_in_req.key),
                .i_load     (alloc && (pick == IDX_W'(g))),
                .i_clear    (accept && !is_on && hit && (hit_idx == IDX_W'(g))),
                .i_hit      (hit_c[g]),
                .i_hit_idx  (hit_idx_c[g]),
                .i_free     (free_c[g]),
                .i_free_idx (free_idx_c[g]),
                .o_hit      (hit_c[g+1]),
                .o_hit_idx  (hit_idx_c[g+1]),
                .o_free     (free_c[g+1]),
                .o_free_idx (free_idx_c[g+1])
            );

            if (g == 0) begin : g_head
                pva_hist_cell #(
                    .IDX_W (IDX_W)
                ) u_hist (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (alloc),
                    .i_din   (pick),
                    .o_slot  (hist[g])
                );
            end else begin : g_tail
                pva_hist_cell #(
                    .IDX_W (IDX_W)
                ) u_hist (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (alloc),
                    .i_din   (hist[g-1]),
                    .o_slot  (hist[g])
                );
            end
        end
    endgenerate

    assign voice_ext = (is_on && !hit) ? EXT_W'(pick) : EXT_W'(hit_idx);

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_rsp   = r_out_rsp;
        if (accept) begin
            n_out_valid        = is_on || hit;
            n_out_rsp.voice    = voice_ext[VOICE_W-1:0];
            n_out_rsp.note_key = i_in_req.key;
            n_out_rsp.stolen   = 1'b0;
            if (!is_on) begin
                n_out_rsp.action = ACT_SILENCE;
                n_out_rsp.level  = '0;
            end else if (hit) begin
                n_out_rsp.action = ACT_VEL_CHANGE;
                n_out_rsp.level  = i_in_req.velocity;
            end else begin
                n_out_rsp.action = ACT_START;
                n_out_rsp.level  = i_in_req.velocity;
                n_out_rsp.stolen = !any_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rsp <= n_out_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

// ----- tb/voice_alloc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_alloc_checker
// Watches both request channels of the voice allocator, tracks voice ownership
// and allocation age, and compares each output request field by field against
// the predicted voice event.
// ----------------------------------------------------------------------------
module voice_alloc_checker #(
    parameter int VOICE_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  pva_pkg::t_in_req  i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  pva_pkg::t_out_rsp i_out_rsp,
    output int                o_fail_count,
    output int                o_pending
);
    import pva_pkg::*;

    localparam logic [7:0] FREE_MARK = 8'hFF;
    localparam int REPORT_MAX = 10;

    logic [7:0]         held_key    [VOICE_COUNT];
    logic [VOICE_W-1:0] alloc_order [VOICE_COUNT];
    t_out_rsp           expected_events[$];
    int                 fail_total;

    function automatic bit allocate_voice(input t_in_req req, output t_out_rsp rsp);
        int pick;
        rsp  = '0;
        pick = -1;
        rsp.note_key = req.key;
        if (req.op == OP_NOTE_ON) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                if (held_key[v] == {1'b0, req.key}) begin
                    rsp.voice  = VOICE_W'(v);
                    rsp.action = ACT_VEL_CHANGE;
                    rsp.level  = req.velocity;
                    return 1'b1;
                end
                if (held_key[v] == FREE_MARK) pick = v;
            end
            if (pick < 0) begin
                pick       = int'(alloc_order[VOICE_COUNT-1]) % VOICE_COUNT;
                rsp.stolen = 1'b1;
            end
            held_key[pick] = {1'b0, req.key};
            for (int h = VOICE_COUNT - 1; h > 0; h--) alloc_order[h] = alloc_order[h-1];
            alloc_order[0] = VOICE_W'(pick);
            rsp.voice  = VOICE_W'(pick);
            rsp.action = ACT_START;
            rsp.level  = req.velocity;
            return 1'b1;
        end
        for (int v = 0; v < VOICE_COUNT; v++) begin
            if (held_key[v] == {1'b0, req.key}) begin
                held_key[v] = FREE_MARK;
                rsp.voice   = VOICE_W'(v);
                rsp.action  = ACT_SILENCE;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_out_rsp want;
        t_out_rsp got;
        if (!i_rst_n) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                held_key[v]    = FREE_MARK;
                alloc_order[v] = '0;
            end
            expected_events.delete();
            fail_total = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_rsp;
                if (expected_events.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_MAX)
                        $display("%0t: unexpected output voice=%0d action=%0d key=%0d",
                                 $realtime, got.voice, got.action, got.note_key,
                                 " level=%0d stolen=%0d", got.level, got.stolen);
                end else begin
                    want = expected_events.pop_front();
                    if (got.voice != want.voice || got.action != want.action ||
                        got.note_key != want.note_key || got.level != want.level ||
                        got.stolen != want.stolen) begin
                        fail_total++;
                        if (fail_total <= REPORT_MAX)
                            $display("%0t: expected voice=%0d action=%0d key=%0d",
                                     $realtime, want.voice, want.action, want.note_key,
                                     " level=%0d stolen=%0d,", want.level, want.stolen,
                                     " got voice=%0d action=%0d key=%0d",
                                     got.voice, got.action, got.note_key,
                                     " level=%0d stolen=%0d", got.level, got.stolen);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (allocate_voice(i_in_req, want)) expected_events.push_back(want);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_events.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives note-on and note-off requests into the voice allocator with random
// gaps and output stalls, including one long output hold-off, and reports the
// verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
    import pva_pkg::*;

    localparam int VOICE_COUNT  = 4;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_OFF     = 200;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_rsp o_out_rsp;
    int       fail_count;
    int       pending;
    int       requests_sent;
    bit       no_idle;
    bit       hold_off_done;

    polyphonic_voice_allocator #(.VOICE_COUNT(VOICE_COUNT)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    voice_alloc_checker #(.VOICE_COUNT(VOICE_COUNT)) checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_rsp    (o_out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_event(input t_op op, input logic [KEY_W-1:0] key,
                              input logic [VEL_W-1:0] vel);
        int      gap;
        t_in_req req;
        gap          = no_idle ? 0 : $urandom_range(0, 5);
        req.op       = op;
        req.key      = key;
        req.velocity = vel;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    // output side: random stalls, one long hold-off to back up the input
    initial begin
        int w;
        i_out_stall   <= 1'b0;
        hold_off_done  = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_off_done && requests_sent >= 500) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            w = no_idle ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VEL_W-1:0] vel;
        requests_sent = 0;
        no_idle       = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill all voices, retrigger, steal, release and reuse
        send_event(OP_NOTE_ON,  7'd0,   7'd0);
        send_event(OP_NOTE_ON,  7'd127, 7'd127);
        send_event(OP_NOTE_ON,  7'd0,   7'd127);
        send_event(OP_NOTE_OFF, 7'd55,  7'd127);
        send_event(OP_NOTE_ON,  7'd64,  7'd1);
        send_event(OP_NOTE_ON,  7'd5,   7'd100);
        send_event(OP_NOTE_ON,  7'd33,  7'd50);
        send_event(OP_NOTE_ON,  7'd90,  7'd85);
        send_event(OP_NOTE_ON,  7'd42,  7'd0);
        send_event(OP_NOTE_OFF, 7'd127, 7'd127);
        send_event(OP_NOTE_OFF, 7'd90,  7'd127);
        send_event(OP_NOTE_OFF, 7'd90,  7'd0);
        send_event(OP_NOTE_ON,  7'd12,  7'd42);
        send_event(OP_NOTE_ON,  7'd42,  7'd127);
        send_event(OP_NOTE_OFF, 7'd42,  7'd85);
        send_event(OP_NOTE_OFF, 7'd33,  7'd0);
        send_event(OP_NOTE_OFF, 7'd12,  7'd1);
        send_event(OP_NOTE_OFF, 7'd5,   7'd0);
        send_event(OP_NOTE_ON,  7'd127, 7'd85);
        send_event(OP_NOTE_ON,  7'd1,   7'd42);
        send_event(OP_NOTE_ON,  7'd2,   7'd21);
        send_event(OP_NOTE_ON,  7'd3,   7'd106);
        send_event(OP_NOTE_ON,  7'd4,   7'd64);
        send_event(OP_NOTE_OFF, 7'd127, 7'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            op  = ($urandom_range(0, 99) < 40) ? OP_NOTE_OFF : OP_NOTE_ON;
            key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 127))
                                              : KEY_W'(60 + $urandom_range(0, 7));
            vel = VEL_W'($urandom_range(0, 127));
            send_event(op, key, vel);
        end
        i_in_valid <= 1'b0;
        no_idle     = 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
